/* design/sia_pkg.sv */
// ----------------------------------------------------------------------------
// sia_pkg: shared types and constants of the signed integer unit
// Opcodes, error codes and the control word between sequencer and datapath.
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int unsigned WordBits = 64;
  localparam int unsigned CntBits  = $clog2(WordBits + 1);

  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_FDIV = 5'd3, OP_MOD = 5'd4,
    OP_AND = 5'd5, OP_OR = 5'd6, OP_XOR = 5'd7, OP_SHL = 5'd8, OP_SAR = 5'd9,
    OP_NEG = 5'd10, OP_NOT = 5'd11, OP_CMP = 5'd12, OP_EQ = 5'd13,
    OP_ABS = 5'd14, OP_BLEN = 5'd15, OP_CLAMP = 5'd16, OP_GCD = 5'd17,
    OP_POW = 5'd18, OP_MIN = 5'd19, OP_MAX = 5'd20
  } op_e;

  typedef enum logic [1:0] {
    ERR_NONE  = 2'd0,
    ERR_DIV0  = 2'd1,
    ERR_SHIFT = 2'd2
  } err_e;

  // Iterative datapath command from the sequencer.
  typedef enum logic [1:0] {
    IT_IDLE = 2'd0,
    IT_DIV  = 2'd1,
    IT_MUL  = 2'd2,
    IT_POW  = 2'd3
  } iter_e;

  typedef struct packed {
    logic  load;     // load dividend/divisor or multiplicand
    iter_e kind;
    logic  step;     // run one iteration
  } seq_ctl_t;

  function automatic logic s_less(word_t a, word_t b);
    return $signed(a) < $signed(b);
  endfunction

  function automatic word_t mag(word_t v);
    return v[WordBits-1] ? (~v + word_t'(1)) : v;
  endfunction

endpackage

/* design/sia_iter.sv */
// ----------------------------------------------------------------------------
// sia_iter: shared shift-add / shift-subtract unit
// One bit per cycle while step is set: restoring division or shift-add multiplication.
// ----------------------------------------------------------------------------
module sia_iter import sia_pkg::*; (
  input  logic     clk_i,
  input  seq_ctl_t ctl_i,
  input  word_t    x_i,       // dividend or multiplicand
  input  word_t    y_i,       // divisor or multiplier
  output word_t    quo_o,     // quotient or product
  output word_t    rem_o
);

  word_t q_q, q_d, r_q, r_d, m_q, m_d;
  logic [WordBits:0] trial;

  always_comb begin
    q_d   = q_q;
    r_d   = r_q;
    m_d   = m_q;
    trial = '0;
    if (ctl_i.load) begin
      q_d = x_i;
      r_d = '0;
      m_d = y_i;
    end else if (ctl_i.step) begin
      if (ctl_i.kind == IT_DIV) begin
        // shift one dividend bit into the partial remainder, try subtract
        trial = {r_q, q_q[WordBits-1]} - {1'b0, m_q};
        if (!trial[WordBits]) begin
          r_d = trial[WordBits-1:0];
          q_d = {q_q[WordBits-2:0], 1'b1};
        end else begin
          r_d = {r_q[WordBits-2:0], q_q[WordBits-1]};
          q_d = {q_q[WordBits-2:0], 1'b0};
        end
      end else begin
        // r accumulates, q shifts multiplicand left, m multiplier right
        if (m_q[0]) r_d = r_q + q_q;
        q_d = {q_q[WordBits-2:0], 1'b0};
        m_d = {1'b0, m_q[WordBits-1:1]};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
    m_q <= m_d;
  end

  assign quo_o = (ctl_i.kind == IT_DIV) ? q_q : r_q;
  assign rem_o = (ctl_i.kind == IT_DIV) ? r_q : m_q;

endmodule

/* design/signed_integer_alu.sv */
// ----------------------------------------------------------------------------
// signed_integer_alu: 64-bit signed integer unit
// Sequencer around one shared bit-serial divide/multiply unit.
// ----------------------------------------------------------------------------
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+------------------------
//  command  | op_i, operand_a_i, operand_b_i, operand_c_i | start_i & !busy_o
//  result   | value_o, error_o                        | done_o, one cycle
//
// Single-cycle ops: computed in S_EXEC, then the done strobe from S_DONE.
// mul: multiply steps in S_MUL; floordiv/mod: 64 divide steps in S_DIV, then S_DIVFIN.
// gcd: up to ~93 remainders, each a full divide on the one shared divider.
// pow: each exponent bit costs up to two 65-step multiplies on the shared unit.
// busy_o stays high from acceptance until the done strobe; results cannot stall.
// Reset clears the sequencer and done strobe; payload registers are not reset.
module signed_integer_alu import sia_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [4:0]  op_i,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  input  logic [63:0] operand_c_i,
  output logic        done_o,
  output logic [63:0] value_o,
  output logic [1:0]  error_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DIV, S_DIVFIN, S_MUL, S_GCD, S_PSQ, S_PMUL, S_PNEXT, S_DONE
  } state_e;

  state_e state_q;
  op_e    op_q;
  word_t  a_q, b_q, c_q;     // a/b also act as gcd x/y and pow base/exponent
  word_t  acc_q;             // pow partial result
  word_t  val_q;
  err_e   err_q;
  logic [CntBits-1:0] cnt_q;
  logic   pow_sq_q;          // pow: the pending multiply is the squaring

  seq_ctl_t ctl;
  word_t    it_x, it_y, it_quo, it_rem;

  sia_iter u_iter (
    .clk_i (clk_i),
    .ctl_i (ctl),
    .x_i   (it_x),
    .y_i   (it_y),
    .quo_o (it_quo),
    .rem_o (it_rem)
  );

  // bit length of v: position of its highest set bit plus one
  function automatic logic [CntBits-1:0] bitlen(word_t v);
    logic [CntBits-1:0] n;
    n = '0;
    for (int i = 0; i < WordBits; i++) begin
      if (v[i]) n = CntBits'(i + 1);
    end
    return n;
  endfunction

  // single-cycle operations
  word_t sc_val;
  err_e  sc_err;
  word_t sar_full;
  always_comb begin
    sc_val   = '0;
    sc_err   = ERR_NONE;
    sar_full = '0;
    case (op_q)
      OP_ADD: sc_val = a_q + b_q;
      OP_SUB: sc_val = a_q - b_q;
      OP_AND: sc_val = a_q & b_q;
      OP_OR:  sc_val = a_q | b_q;
      OP_XOR: sc_val = a_q ^ b_q;
      OP_SHL: begin
        if (b_q[WordBits-1]) sc_err = ERR_SHIFT;
        else if (b_q >= word_t'(WordBits)) sc_val = '0;
        else sc_val = a_q << b_q[CntBits-2:0];
      end
      OP_SAR: begin
        sar_full = $signed(a_q) >>> b_q[CntBits-2:0];
        if (b_q[WordBits-1]) sc_err = ERR_SHIFT;
        else if (b_q >= word_t'(WordBits)) sc_val = {WordBits{a_q[WordBits-1]}};
        else sc_val = sar_full;
      end
      OP_NEG:  sc_val = ~a_q + word_t'(1);
      OP_NOT:  sc_val = ~a_q;
      OP_CMP:  sc_val = s_less(a_q, b_q) ? '1 : (s_less(b_q, a_q) ? word_t'(1) : '0);
      OP_EQ:   sc_val = word_t'(a_q == b_q);
      OP_ABS:  sc_val = mag(a_q);
      OP_BLEN: sc_val = word_t'(bitlen(mag(a_q)));
      OP_CLAMP: sc_val = s_less(a_q, b_q) ? b_q : (s_less(c_q, a_q) ? c_q : a_q);
      OP_MIN:  sc_val = s_less(b_q, a_q) ? b_q : a_q;
      OP_MAX:  sc_val = s_less(a_q, b_q) ? b_q : a_q;
      default: sc_val = '0;
    endcase
  end

  // drive the shared unit
  always_comb begin
    ctl  = '{load: 1'b0, kind: IT_IDLE, step: 1'b0};
    it_x = '0;
    it_y = '0;
    unique case (state_q)
      S_EXEC: begin
        ctl.load = 1'b1;
        unique case (op_q)
          OP_MUL:  begin ctl.kind = IT_MUL; it_x = a_q; it_y = b_q; end
          OP_FDIV, OP_MOD, OP_GCD: begin
            ctl.kind = IT_DIV; it_x = mag(a_q); it_y = mag(b_q);
          end
          default: begin ctl.kind = IT_MUL; it_x = acc_q; it_y = a_q; end
        endcase
      end
      S_DIV, S_DIVFIN: begin ctl.kind = IT_DIV; ctl.step = (state_q == S_DIV); end
      S_GCD: begin ctl.kind = IT_DIV; ctl.load = 1'b1; it_x = a_q; it_y = b_q; end
      S_MUL, S_PMUL, S_PSQ: begin ctl.kind = IT_MUL; ctl.step = 1'b1; end
      S_PNEXT: begin
        ctl.kind = IT_MUL; ctl.load = 1'b1;
        if (pow_sq_q) begin it_x = a_q; it_y = a_q; end
        else begin it_x = acc_q; it_y = a_q; end
      end
      default: ;
    endcase
  end

  logic diff_sign;
  assign diff_sign = a_q[WordBits-1] ^ b_q[WordBits-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      pow_sq_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: if (start_i) begin
          op_q    <= op_e'(op_i);
          a_q     <= operand_a_i;
          b_q     <= operand_b_i;
          c_q     <= operand_c_i;
          acc_q   <= word_t'(1);
          state_q <= S_EXEC;
        end
        S_EXEC: begin
          val_q   <= sc_val;
          err_q   <= sc_err;
          cnt_q   <= '0;
          state_q <= S_DONE;
          unique case (op_q)
            OP_MUL: state_q <= S_MUL;
            OP_FDIV, OP_MOD: begin
              if (b_q == '0) begin
                val_q <= '0; err_q <= ERR_DIV0;
              end else state_q <= S_DIV;
            end
            OP_GCD: begin
              // a,b become magnitudes; divider was loaded anyway
              a_q <= mag(a_q);
              b_q <= mag(b_q);
              if (b_q == '0) val_q <= mag(a_q);
              else state_q <= S_DIV;
            end
            OP_POW: begin
              if (b_q[WordBits-1]) val_q <= '0;
              else if (b_q == '0) val_q <= word_t'(1);
              else begin
                // first action: multiply acc by base if exponent bit set
                pow_sq_q <= !b_q[0];
                state_q  <= S_PNEXT;
              end
            end
            default: ;
          endcase
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntBits'(WordBits - 1)) state_q <= S_DIVFIN;
        end
        S_DIVFIN: begin
          state_q <= S_DONE;
          err_q   <= ERR_NONE;
          unique case (op_q)
            OP_FDIV: begin
              if (diff_sign)
                val_q <= ~it_quo + word_t'(1) - word_t'(it_rem != '0);
              else
                val_q <= it_quo;
            end
            OP_MOD: val_q <= a_q[WordBits-1] ? (~it_rem + word_t'(1)) : it_rem;
            default: begin
              // gcd: (x, y) <- (y, x mod y)
              a_q <= b_q;
              b_q <= it_rem;
              if (it_rem == '0) val_q <= b_q;
              else state_q <= S_GCD;
            end
          endcase
        end
        S_GCD: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_MUL: begin
          cnt_q <= cnt_q + 1'b1;
          // all 64 steps are in the product once the count reaches the width
          if (cnt_q == CntBits'(WordBits)) begin
            val_q   <= it_quo;
            err_q   <= ERR_NONE;
            state_q <= S_DONE;
          end
        end
        S_PNEXT: begin
          cnt_q   <= '0;
          state_q <= pow_sq_q ? S_PSQ : S_PMUL;
        end
        S_PMUL: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntBits'(WordBits)) begin
            acc_q <= it_quo;
            // exponent bit consumed; square base next unless this was the last
            if (b_q[WordBits-1:1] == '0) begin
              val_q <= it_quo; err_q <= ERR_NONE; state_q <= S_DONE;
            end else begin
              pow_sq_q <= 1'b1; state_q <= S_PNEXT;
            end
          end
        end
        S_PSQ: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntBits'(WordBits)) begin
            a_q      <= it_quo;
            b_q      <= {1'b0, b_q[WordBits-1:1]};
            // next exponent bit: multiply if set, otherwise square again
            pow_sq_q <= !b_q[1];
            state_q  <= S_PNEXT;
          end
        end
        S_DONE: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o  = (state_q != S_IDLE);
  assign done_o  = (state_q == S_DONE);
  assign value_o = val_q;
  assign error_o = err_q;

endmodule

/* design/sia_checker.sv */
// ----------------------------------------------------------------------------
// sia_checker: port-level checks of the signed integer unit
// Watches command and result handshakes over time.
// ----------------------------------------------------------------------------
module sia_checker import sia_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        done_o,
  input logic [1:0]  error_o
);

  // accepted word makes the unit busy next cycle
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o) else $error("not busy after accept");

  // the done strobe lasts one cycle
  a_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done held");

  // done only while busy, and busy drops right after
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o ##1 !busy_o) else $error("done outside busy");

  // error code never takes the unused value
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> error_o != 2'd3) else $error("bad error code");

endmodule

bind signed_integer_alu sia_checker u_sia_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .error_o (error_o)
);
